// ===== src/cv3_pkg.sv =====
// cv3_pkg: shared types and constants of the 3x3 window filter.
// No dependencies; imported by cv3_result_if, cv3_cell and conv3x3_window_filter.
package cv3_pkg;

  // Output sum width and fixed image limits
  localparam int OUT_BITS       = 20;
  localparam int MAX_HEIGHT     = 128;
  localparam int TAPS           = 3;
  localparam int SIZE_REG_BITS  = 8;
  localparam int ROW_BITS       = 8;
  localparam int CFG_INDEX_BITS = 3;

  // Reset values of the size and kernel registers
  localparam int WIDTH_RESET      = 16;
  localparam int HEIGHT_RESET     = 16;
  localparam int KERNEL_MID_RESET = 'h010000;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_index_t;

  // Per-beat control handed to each window cell
  typedef struct packed {
    logic            en;       // shift the window and capture products
    logic            zero_in;  // neighbor column reads as zero (image restart)
    logic            clear;    // clear the column after this beat (image end)
    logic [TAPS-1:0] row_ok;   // kernel rows that lie inside the image
    logic            col_ok;   // this kernel column lies inside the image
  } cell_ctl_t;

endpackage

// ===== src/cv3_pixel_if.sv =====
// cv3_pixel_if: input stream of pixel beats (valid/ready handshake).
// No dependencies.
interface cv3_pixel_if #(
  parameter int PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output mode, output pixel, input ready);
  modport sink   (input valid, input mode, input pixel, output ready);
endinterface

// ===== src/cv3_result_if.sv =====
// cv3_result_if: output stream of filtered results (valid/ready handshake).
// Depends on cv3_pkg for the result width.
interface cv3_result_if import cv3_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] filtered;
  logic                       last;

  modport source (output valid, output filtered, output last, input ready);
  modport sink   (input valid, input filtered, input last, output ready);
endinterface

// ===== src/cv3_line_store.sv =====
// cv3_line_store: one row of pixels, one write and one registered read port.
// A read at the address written in the same cycle returns the new data.
module cv3_line_store #(
  parameter  int DATA_BITS = 8,
  parameter  int DEPTH     = 128,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [DATA_BITS-1:0] rdata_r;

  // Write port, read port with write-through bypass
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/cv3_cell.sv =====
// cv3_cell: one column of the 3x3 window plus its three coefficient taps.
// Depends on cv3_pkg; cells are chained so each but the rightmost takes its right neighbor's column.
module cv3_cell import cv3_pkg::*; #(
  parameter  int PIXEL_BITS = 8,
  parameter  int COEFF_BITS = 8,
  localparam int PROD_BITS  = PIXEL_BITS + COEFF_BITS + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cell_ctl_t                       ctl,
  input  logic [TAPS-1:0][PIXEL_BITS-1:0] col_in,
  input  logic [TAPS-1:0][COEFF_BITS-1:0] coef,
  output logic [TAPS-1:0][PIXEL_BITS-1:0] col_q,
  output logic [TAPS-1:0][PROD_BITS-1:0]  prod_q
);

  logic [TAPS-1:0][PIXEL_BITS-1:0] col_r;
  logic [TAPS-1:0][PIXEL_BITS-1:0] col_new;
  logic [TAPS-1:0][PROD_BITS-1:0]  prod_r;
  logic signed [PROD_BITS-1:0]     prod_nxt [TAPS];

  // Column shifted in this beat (neighbor zeroed on image restart)
  assign col_new = ctl.zero_in ? '0 : col_in;

  // Masked products of the new column
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      if (ctl.row_ok[i] && ctl.col_ok) begin
        prod_nxt[i] = $signed({1'b0, col_new[i]}) * $signed(coef[i]);
      end else begin
        prod_nxt[i] = '0;
      end
    end
  end

  // Window column state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (ctl.en) begin
      col_r <= ctl.clear ? '0 : col_new;
    end
  end

  // Product registers
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < TAPS; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
  end

  assign col_q  = col_r;
  assign prod_q = prod_r;

endmodule

// ===== src/conv3x3_window_filter.sv =====
// conv3x3_window_filter: streaming 3x3 correlation, raster order, zero padding.
// A result moves through the stage 1 register, the cell product registers and the output register to out_bus.
// Throughput: one pixel beat per cycle; the three-stage pipeline stalls only on out_bus.ready.
// Reset (rst_n, synchronous): config to defaults, counters, window and pipeline cleared;
// line stores are not cleared and need no clearing pass.
// Depends on cv3_pkg, cv3_pixel_if, cv3_result_if, cv3_line_store, cv3_cell.
module conv3x3_window_filter import cv3_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int PIXEL_BITS = 8,
  parameter int COEFF_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cv3_pixel_if.sink                 in_bus,
  cv3_result_if.source              out_bus,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((TAPS*COEFF_BITS > SIZE_REG_BITS) ? TAPS*COEFF_BITS : SIZE_REG_BITS)-1:0]
                                    cfg_wdata
);

  localparam int KB        = TAPS * COEFF_BITS;
  localparam int CW        = $clog2(MAX_WIDTH + 1);
  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int WB        = (CW > SIZE_REG_BITS) ? CW : SIZE_REG_BITS;
  localparam int PROD_BITS = PIXEL_BITS + COEFF_BITS + 1;
  localparam int SB        = PROD_BITS + 4;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] px;
    logic [AW-1:0]         addr;
    logic                  top_ok;
    logic                  mid_ok;
    logic                  zero_before;
    logic                  last;
    logic                  has_res;
    logic [TAPS-1:0]       row_ok;
    logic [TAPS-1:0]       col_ok;
  } stage_t;

  // ---------------- configuration registers ----------------
  logic [SIZE_REG_BITS-1:0]   size_w_r;
  logic [SIZE_REG_BITS-1:0]   size_h_r;
  logic [TAPS-1:0][KB-1:0]    kern_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_w_r  <= SIZE_REG_BITS'(WIDTH_RESET);
      size_h_r  <= SIZE_REG_BITS'(HEIGHT_RESET);
      kern_r[0] <= '0;
      kern_r[1] <= KB'(KERNEL_MID_RESET);
      kern_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:   size_w_r  <= cfg_wdata[SIZE_REG_BITS-1:0];
        CFG_IMAGE_HEIGHT:  size_h_r  <= cfg_wdata[SIZE_REG_BITS-1:0];
        CFG_KERNEL_TOP:    kern_r[0] <= cfg_wdata[KB-1:0];
        CFG_KERNEL_MIDDLE: kern_r[1] <= cfg_wdata[KB-1:0];
        CFG_KERNEL_BOTTOM: kern_r[2] <= cfg_wdata[KB-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake and stage control ----------------
  logic   s1_valid_r, s2_valid_r, s2_last_r, out_valid_r;
  logic   s2_adv, s2_free, s1_adv, s1_free, accept;
  stage_t s1_r, st0;

  assign s2_adv  = s2_valid_r && (!out_valid_r || out_bus.ready);
  assign s2_free = !s2_valid_r || s2_adv;
  assign s1_adv  = s1_valid_r && s2_free;
  assign s1_free = !s1_valid_r || s1_adv;
  assign accept  = in_bus.valid && s1_free;
  assign in_bus.ready = s1_free;

  // ---------------- stage 0: position tracking ----------------
  logic [CW-1:0]       col_cnt_r, col_nxt, c0, w_cl, ccol;
  logic [ROW_BITS-1:0] row_cnt_r, row_nxt, r0, h_cl, crow;
  logic [WB-1:0]       w_ext;
  logic                n_wrap, n_mid;

  assign w_ext = WB'(size_w_r);

  // Clamp width and height to their legal ranges
  always_comb begin
    if (size_w_r == '0) begin
      w_cl = CW'(1);
    end else if (w_ext > WB'(MAX_WIDTH)) begin
      w_cl = CW'(MAX_WIDTH);
    end else begin
      w_cl = CW'(w_ext);
    end
    if (size_h_r == '0) begin
      h_cl = ROW_BITS'(1);
    end else if (size_h_r > SIZE_REG_BITS'(MAX_HEIGHT)) begin
      h_cl = ROW_BITS'(MAX_HEIGHT);
    end else begin
      h_cl = ROW_BITS'(size_h_r);
    end
  end

  // Row wrap, image restart, result centre and padding masks
  always_comb begin
    c0 = col_cnt_r;
    r0 = row_cnt_r;
    st0 = '0;
    if (c0 >= w_cl) begin
      c0 = '0;
      r0 = ROW_BITS'(r0 + ROW_BITS'(1));
    end
    if ({1'b0, r0} > ({1'b0, h_cl} + 9'd1)) begin
      c0 = '0;
      r0 = '0;
      st0.zero_before = 1'b1;
    end
    n_wrap = (c0 == '0) && (r0 >= ROW_BITS'(2));
    n_mid  = (c0 != '0) && (r0 != '0);
    crow = '0;
    ccol = '0;
    if (n_wrap) begin
      crow = ROW_BITS'(r0 - ROW_BITS'(2));
      ccol = CW'(w_cl - CW'(1));
    end else if (n_mid) begin
      crow = ROW_BITS'(r0 - ROW_BITS'(1));
      ccol = CW'(c0 - CW'(1));
    end
    st0.px      = in_bus.mode ? '0 : in_bus.pixel;
    st0.addr    = c0[AW-1:0];
    st0.top_ok  = r0 >= ROW_BITS'(2);
    st0.mid_ok  = r0 != '0;
    st0.has_res = n_wrap || n_mid;
    st0.last    = st0.has_res && (crow == ROW_BITS'(h_cl - ROW_BITS'(1)))
                  && (ccol == CW'(w_cl - CW'(1)));
    st0.row_ok[0] = crow != '0;
    st0.row_ok[1] = crow < h_cl;
    st0.row_ok[2] = ({1'b0, crow} + 9'd1) < {1'b0, h_cl};
    st0.col_ok[0] = ccol != '0;
    st0.col_ok[1] = ccol < w_cl;
    st0.col_ok[2] = ({1'b0, ccol} + (CW+1)'(1)) < {1'b0, w_cl};
    if (st0.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else begin
      col_nxt = CW'(c0 + CW'(1));
      row_nxt = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // ---------------- line stores ----------------
  logic [PIXEL_BITS-1:0] top_rd, mid_rd;

  cv3_line_store #(.DATA_BITS(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_r.addr),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (st0.addr),
    .rdata (top_rd)
  );

  cv3_line_store #(.DATA_BITS(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_r.addr),
    .wdata (s1_r.px),
    .re    (accept),
    .raddr (st0.addr),
    .rdata (mid_rd)
  );

  // ---------------- stage 1 register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= st0;
    end
  end

  // ---------------- window: chain of column cells ----------------
  logic [TAPS-1:0][PIXEL_BITS-1:0]            col_fresh;
  logic [TAPS-1:0][TAPS-1:0][PIXEL_BITS-1:0]  cell_in, cell_q;
  logic [TAPS-1:0][TAPS-1:0][COEFF_BITS-1:0]  cell_coef;
  logic [TAPS-1:0][TAPS-1:0][PROD_BITS-1:0]   cell_prod;
  cell_ctl_t [TAPS-1:0]                       cell_ctl;

  // New right-hand column: top and middle rows padded above the image
  assign col_fresh[0] = s1_r.top_ok ? top_rd : '0;
  assign col_fresh[1] = s1_r.mid_ok ? mid_rd : '0;
  assign col_fresh[2] = s1_r.px;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == TAPS - 1) begin : g_edge
      assign cell_in[k]          = col_fresh;
      assign cell_ctl[k].zero_in = 1'b0;
    end else begin : g_link
      assign cell_in[k]          = cell_q[k+1];
      assign cell_ctl[k].zero_in = s1_r.zero_before;
    end
    assign cell_ctl[k].en     = s1_adv;
    assign cell_ctl[k].clear  = s1_r.last;
    assign cell_ctl[k].row_ok = s1_r.row_ok;
    assign cell_ctl[k].col_ok = s1_r.col_ok[k];
    for (genvar i = 0; i < TAPS; i++) begin : g_coef
      assign cell_coef[k][i] = kern_r[i][k*COEFF_BITS +: COEFF_BITS];
    end

    cv3_cell #(.PIXEL_BITS(PIXEL_BITS), .COEFF_BITS(COEFF_BITS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (cell_ctl[k]),
      .col_in (cell_in[k]),
      .coef   (cell_coef[k]),
      .col_q  (cell_q[k]),
      .prod_q (cell_prod[k])
    );
  end

  // ---------------- stage 2: products held in the cells ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= s1_r.has_res;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_last_r <= s1_r.last;
    end
  end

  // Sum of the nine products
  logic signed [SB-1:0] sum;

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      for (int i = 0; i < TAPS; i++) begin
        sum = sum + SB'($signed(cell_prod[k][i]));
      end
    end
  end

  // ---------------- output register ----------------
  logic signed [OUT_BITS-1:0] out_filtered_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_filtered_r <= OUT_BITS'(sum);
      out_last_r     <= s2_last_r;
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.filtered = out_filtered_r;
  assign out_bus.last     = out_last_r;

  // ---------------- assertions ----------------
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && st0.last) |=> (col_cnt_r == '0 && row_cnt_r == '0))
    else $error("position counters not cleared after the last result beat");

  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_adv))
    else $error("output valid rose without a result leaving stage 2");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_adv) |=> s2_valid_r)
    else $error("stalled stage 2 result was dropped");

endmodule
